@@ hw/rtl/lid_motor_controller_top_assert.svh @@
// Assertion macros for the lid motor controller.
// Used inside lid_motor_controller_top; expects a clk and rst_n in scope.
`ifndef LID_MOTOR_CONTROLLER_TOP_ASSERT_SVH
`define LID_MOTOR_CONTROLLER_TOP_ASSERT_SVH

// Checked only out of reset.
`define LMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define LMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/lmc_pkg.sv @@
// Package for the lid motor controller: beat types, register indexes,
// reset values and status codes. No dependencies.
package lmc_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_SPEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_SPEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_THR   = 2'd2;

  localparam logic [7:0]  OPEN_SPEED_RST  = 8'd200;
  localparam logic [7:0]  CLOSE_SPEED_RST = 8'd200;
  localparam logic [15:0] STALL_THR_RST   = 16'd650;

  localparam int unsigned RAMP_STEP_DEF = 2;
  localparam int unsigned MIN_DRIVE_DEF = 80;
  localparam logic [9:0]  MAX_DRIVE     = 10'd255;
  localparam logic [5:0]  GATE_MS       = 6'd50;

  // lid_status codes
  localparam logic [1:0] ST_OPENED  = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_CLOSED  = 2'd2;
  localparam logic [1:0] ST_STUCK   = 2'd3;

  // error_flags bit positions
  localparam int unsigned ERR_SENSOR   = 0;
  localparam int unsigned ERR_SPARE    = 1;
  localparam int unsigned ERR_LOCK_SW  = 2;
  localparam int unsigned ERR_LOCK_CTL = 3;

  // button_flags bit positions
  localparam int unsigned BTN_CLOSED = 0;
  localparam int unsigned BTN_OPEN   = 1;
  localparam int unsigned BTN_LOCK   = 2;
  localparam int unsigned BTN_SPARE  = 3;

  typedef struct packed {
    logic               cmd;
    logic               run_direction;
    logic               closed_limit;
    logic               open_limit;
    logic               lock_switch;
    logic               close_button;
    logic [7:0]         elapsed_ms;
    logic               sample_valid;
    logic               raw_current_zero;
    logic signed [15:0] filtered_current_ma;
  } in_item_t;

  typedef struct packed {
    logic signed [8:0] motor_drive;
    logic [1:0]        lid_status;
    logic [3:0]        error_flags;
    logic              lock_enable;
    logic [3:0]        button_flags;
    logic [15:0]       current_ma;
  } out_item_t;

endpackage

@@ hw/rtl/lid_motor_controller_top.sv @@
// Lid motor controller: one decision pass per input beat.
// Depends on lmc_pkg and lid_motor_controller_top_assert.svh.
//
// Usage
//   Input channel (in_valid / in_stall / in_data): one beat per control tick
//   carrying the host command, limit and lock switches, the close button,
//   the elapsed time and an optional filtered current sample.
//   Result channel (out_valid / out_stall / out_data): exactly one beat per
//   input beat, in order: signed drive, lid status, error, lock and switch
//   flags and the held current magnitude.
//   Config port (cfg_wr_en / cfg_index / cfg_wdata): opening speed, closing
//   speed and stall threshold; write only while no beat is in flight.
// Timing
//   A beat is captured in an input register, evaluated against the lid
//   state in one pass of logic, and lands in the result register, which
//   drives out_valid; while out_stall holds a result, the beat waits in
//   the input register. One beat per cycle sustained while out_stall is low;
//   the single decision pass is the only thing between the two registers.
// Reset / backpressure
//   Synchronous active-low reset empties both registers, loads the register
//   defaults and puts the lid state at its reset values (target = +200, so
//   the first beats drive an open run). While out_stall holds a result, the
//   input register keeps its beat and in_stall rises once it is occupied.
module lid_motor_controller_top
  import lmc_pkg::*;
#(
  parameter int unsigned RAMP_STEP = RAMP_STEP_DEF,  // 1..16
  parameter int unsigned MIN_DRIVE = MIN_DRIVE_DEF   // 0..255
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // config writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic signed [10:0] STEP_S  = 11'(RAMP_STEP);
  localparam logic signed [9:0]  STEP_R  = 10'(RAMP_STEP);
  localparam logic [9:0]         MIN_MAG = 10'(MIN_DRIVE);

  // ---------------- config registers ----------------
  logic [7:0]  open_spd_r;
  logic [7:0]  close_spd_r;
  logic [15:0] stall_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_spd_r  <= OPEN_SPEED_RST;
      close_spd_r <= CLOSE_SPEED_RST;
      stall_thr_r <= STALL_THR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_OPEN_SPEED:  open_spd_r  <= cfg_wdata[7:0];
        CFG_CLOSE_SPEED: close_spd_r <= cfg_wdata[7:0];
        CFG_STALL_THR:   stall_thr_r <= cfg_wdata;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // ---------------- handshake / pipeline control ----------------
  logic     s1_vld_r, s1_vld_nxt;
  in_item_t s1_item_r;
  logic     out_vld_r, out_vld_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic     adv;  // stage-1 beat is evaluated and moved to the result reg
  logic     in_take;

  assign adv         = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall    = s1_vld_r && !adv;
  assign in_take     = in_valid && !in_stall;
  assign s1_vld_nxt  = in_take || (s1_vld_r && !adv);
  assign out_vld_nxt = adv || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_item_r  <= in_data;
    if (adv)     out_item_r <= out_item_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // ---------------- lid state ----------------
  logic signed [8:0] tgt_r,    tgt_nxt;
  logic signed [9:0] ramp_r,   ramp_nxt;
  logic              stuck_r,  stuck_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [3:0]        err_r,    err_nxt;
  logic              lock_r,   lock_nxt;
  logic [3:0]        btn_r,    btn_nxt;
  logic [5:0]        gate_r,   gate_nxt;
  logic [15:0]       cur_r,    cur_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r    <= $signed({1'b0, OPEN_SPEED_RST});
      ramp_r   <= '0;
      stuck_r  <= 1'b0;
      status_r <= ST_OPENED;
      err_r    <= '0;
      lock_r   <= 1'b0;
      btn_r    <= '0;
      gate_r   <= GATE_MS;
      cur_r    <= '0;
    end else if (adv) begin
      tgt_r    <= tgt_nxt;
      ramp_r   <= ramp_nxt;
      stuck_r  <= stuck_nxt;
      status_r <= status_nxt;
      err_r    <= err_nxt;
      lock_r   <= lock_nxt;
      btn_r    <= btn_nxt;
      gate_r   <= gate_nxt;
      cur_r    <= cur_nxt;
    end
  end

  // ---------------- decision pass ----------------
  logic [8:0]         gate_sum;
  logic signed [8:0]  open_tgt, close_tgt;
  logic               limit_stop;
  logic signed [10:0] diff;
  logic signed [9:0]  ramp_val;
  logic [9:0]         mag;
  logic [7:0]         mag8;
  logic [8:0]         drive;
  logic [15:0]        smp_mag;

  assign open_tgt  = $signed({1'b0, open_spd_r});
  assign close_tgt = $signed(9'(-{1'b0, close_spd_r}));

  always_comb begin
    tgt_nxt    = tgt_r;
    ramp_nxt   = ramp_r;
    stuck_nxt  = stuck_r;
    status_nxt = status_r;
    err_nxt    = err_r;
    lock_nxt   = lock_r;
    btn_nxt    = btn_r;
    cur_nxt    = cur_r;
    limit_stop = 1'b0;

    // close-button gate, saturating at GATE_MS
    gate_sum = 9'(gate_r) + 9'(s1_item_r.elapsed_ms);
    gate_nxt = (gate_sum > 9'(GATE_MS)) ? GATE_MS : gate_sum[5:0];

    // host run request, only when idle
    if (s1_item_r.cmd && tgt_nxt == 9'sd0) begin
      tgt_nxt   = s1_item_r.run_direction ? open_tgt : close_tgt;
      stuck_nxt = 1'b0;
    end

    // local close button
    if (s1_item_r.close_button && tgt_nxt == 9'sd0 && !s1_item_r.closed_limit &&
        gate_nxt >= GATE_MS) begin
      tgt_nxt  = close_tgt;
      gate_nxt = '0;
    end

    // opening: open limit stops, else lock check
    if (tgt_nxt > 9'sd0) begin
      if (!s1_item_r.open_limit) begin
        lock_nxt = 1'b1;
        if (s1_item_r.lock_switch) begin
          err_nxt[ERR_LOCK_CTL] = 1'b0;
        end else begin
          tgt_nxt               = '0;
          status_nxt            = ST_STUCK;
          err_nxt[ERR_LOCK_CTL] = 1'b1;
        end
      end else begin
        stuck_nxt  = 1'b0;
        tgt_nxt    = '0;
        limit_stop = 1'b1;
        status_nxt = ST_OPENED;
      end
    end
    // closing: closed limit stops
    if (tgt_nxt < 9'sd0 && s1_item_r.closed_limit) begin
      stuck_nxt  = 1'b0;
      tgt_nxt    = '0;
      limit_stop = 1'b1;
      status_nxt = ST_CLOSED;
    end

    // track the current speed registers
    if (tgt_nxt < 9'sd0) tgt_nxt = close_tgt;
    if (tgt_nxt > 9'sd0) tgt_nxt = open_tgt;

    // ramp: inside one step output the goal (ramp kept), else move ramp by one step
    diff = 11'(tgt_nxt) - 11'(ramp_nxt);
    if (diff > -STEP_S && diff < STEP_S) begin
      ramp_val = 10'(tgt_nxt);
    end else begin
      ramp_nxt = (diff > 11'sd0) ? ramp_nxt + STEP_R : ramp_nxt - STEP_R;
      ramp_val = ramp_nxt;
    end
    if (limit_stop) begin
      ramp_val = '0;
      ramp_nxt = '0;
    end

    // clip nonzero magnitude to MIN..MAX
    mag = ramp_val[9] ? 10'(-ramp_val) : 10'(ramp_val);
    if (mag < MIN_MAG)   mag = MIN_MAG;
    if (mag > MAX_DRIVE) mag = MAX_DRIVE;
    mag8 = mag[7:0];
    if (ramp_val == 10'sd0)
      drive = '0;
    else
      drive = ramp_val[9] ? 9'(-{1'b0, mag8}) : {1'b0, mag8};

    if (!s1_item_r.closed_limit && !s1_item_r.open_limit && !stuck_nxt)
      status_nxt = ST_RUNNING;

    // current sample: sensor flag and stall detect
    smp_mag = s1_item_r.filtered_current_ma[15] ?
              16'(-s1_item_r.filtered_current_ma) : 16'(s1_item_r.filtered_current_ma);
    if (s1_item_r.sample_valid) begin
      err_nxt[ERR_SENSOR] = s1_item_r.raw_current_zero;
      cur_nxt             = smp_mag;
      if (smp_mag >= stall_thr_r) begin
        drive      = '0;
        tgt_nxt    = '0;
        stuck_nxt  = 1'b1;
        status_nxt = ST_STUCK;
      end
    end

    // idle: lock switch flag and lock release
    if (tgt_nxt == 9'sd0) begin
      if (s1_item_r.lock_switch) begin
        err_nxt[ERR_LOCK_SW] = 1'b1;
        lock_nxt             = 1'b0;
      end else begin
        err_nxt[ERR_LOCK_SW] = 1'b0;
      end
    end

    // switch flags, priority closed > open > lock
    if (s1_item_r.closed_limit) begin
      btn_nxt[BTN_CLOSED] = 1'b1;
      btn_nxt[BTN_OPEN]   = 1'b0;
    end else if (s1_item_r.open_limit) begin
      btn_nxt[BTN_OPEN]   = 1'b1;
      btn_nxt[BTN_CLOSED] = 1'b0;
    end else begin
      btn_nxt[BTN_LOCK] = s1_item_r.lock_switch;
    end

    out_item_nxt.motor_drive  = $signed(drive);
    out_item_nxt.lid_status   = status_nxt;
    out_item_nxt.error_flags  = err_nxt;
    out_item_nxt.lock_enable  = lock_nxt;
    out_item_nxt.button_flags = btn_nxt;
    out_item_nxt.current_ma   = cur_nxt;
  end

  // ---------------- assertions ----------------
  logic [8:0] out_mag;
  assign out_mag = out_item_r.motor_drive[8] ? 9'(-out_item_r.motor_drive)
                                             : 9'(out_item_r.motor_drive);

`include "lid_motor_controller_top_assert.svh"

  `LMC_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid && !in_stall, "pipeline not empty after reset")
  `LMC_ASSERT(a_s1_hold, s1_vld_r && !adv |=> s1_vld_r && $stable(s1_item_r), "stage-1 beat lost while blocked")
  `LMC_ASSERT(a_beat_moves, adv |=> out_valid, "evaluated beat missing at result register")
  `LMC_ASSERT(a_drive_range, out_valid |-> out_mag == 9'd0 || (out_mag >= 9'(MIN_DRIVE) && out_mag <= 9'd255), "drive magnitude outside clip range")
  `LMC_ASSERT(a_spare_bits, out_valid |-> !out_data.error_flags[ERR_SPARE] && !out_data.button_flags[BTN_SPARE], "spare flag bit set")

endmodule

@@ test/tb_lid_motor_controller_top.sv @@
// Self-checking testbench for lid_motor_controller_top: directed and random beats,
// each result checked against an in-bench prediction of the lid decision pass.
// Depends on lmc_pkg and the RTL of lid_motor_controller_top only.
module tb_lid_motor_controller_top;
  import lmc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Signed copies of the package limits, so that negation stays signed.
  localparam int STEP    = RAMP_STEP_DEF;
  localparam int MIN_MAG = MIN_DRIVE_DEF;
  localparam int MAX_MAG = MAX_DRIVE;
  localparam int GATE    = GATE_MS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  lid_motor_controller_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock, starts low.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idling knobs, in percent per cycle.
  int unsigned send_idle_pct = 0;
  int unsigned rx_stall_pct  = 0;

  int unsigned beats_sent     = 0;
  int unsigned mismatch_count = 0;

  // Expected result beats, oldest first.
  out_item_t lid_results_q[$];
  out_item_t want;

  // Predicted lid state. Register copies start at their reset values.
  logic [7:0]        lid_open_spd  = OPEN_SPEED_RST;
  logic [7:0]        lid_close_spd = CLOSE_SPEED_RST;
  logic [15:0]       lid_stall_thr = STALL_THR_RST;
  logic signed [8:0] lid_target    = 9'sd200;  // reset target opens the lid
  logic signed [9:0] drive_ramp    = '0;
  logic              stuck_latched = 1'b0;
  logic [1:0]        status_q      = ST_OPENED;
  logic [3:0]        error_q       = '0;
  logic              lock_q        = 1'b0;
  logic [3:0]        switch_q      = '0;
  logic [5:0]        gate_ms       = GATE_MS;  // gate starts open
  logic [15:0]       current_q     = '0;

  // One decision pass: updates the predicted state, returns the result beat.
  function automatic out_item_t lid_decision(input in_item_t b);
    int tgt;
    int rmp;
    int diff;
    int drv;
    int mag;
    int gate;
    bit limit_stop;
    out_item_t r;
    tgt = lid_target;
    rmp = drive_ramp;
    limit_stop = 1'b0;

    // Close-button gate: accumulate, saturate at 50 ms.
    gate = int'(gate_ms) + int'(b.elapsed_ms);
    if (gate > GATE) gate = GATE;

    // Host request only counts while the target is zero.
    if (b.cmd && tgt == 0) begin
      tgt = b.run_direction ? int'(lid_open_spd) : -int'(lid_close_spd);
      stuck_latched = 1'b0;
    end
    if (b.close_button && tgt == 0 && !b.closed_limit && gate >= GATE) begin
      tgt = -int'(lid_close_spd);
      gate = 0;
    end

    // Opening: lock check, or stop at the open limit.
    if (tgt > 0) begin
      if (!b.open_limit) begin
        lock_q = 1'b1;
        if (b.lock_switch) begin
          error_q[ERR_LOCK_CTL] = 1'b0;
        end else begin
          tgt = 0;
          status_q = ST_STUCK;
          error_q[ERR_LOCK_CTL] = 1'b1;
        end
      end else begin
        stuck_latched = 1'b0;
        tgt = 0;
        limit_stop = 1'b1;
        status_q = ST_OPENED;
      end
    end
    if (tgt < 0 && b.closed_limit) begin
      stuck_latched = 1'b0;
      tgt = 0;
      limit_stop = 1'b1;
      status_q = ST_CLOSED;
    end

    // Running targets follow the current speed registers.
    if (tgt < 0) tgt = -int'(lid_close_spd);
    if (tgt > 0) tgt = int'(lid_open_spd);

    // Ramp: within one step the goal is output but the ramp level stays put.
    diff = tgt - rmp;
    if (diff > -STEP && diff < STEP) begin
      drv = tgt;
    end else begin
      rmp = rmp + ((diff > 0) ? STEP : -STEP);
      drv = rmp;
    end
    if (limit_stop) begin
      drv = 0;
      rmp = 0;
    end
    if (drv != 0) begin
      mag = (drv < 0) ? -drv : drv;
      if (mag < MIN_MAG) mag = MIN_MAG;
      if (mag > MAX_MAG) mag = MAX_MAG;
      drv = (drv < 0) ? -mag : mag;
    end

    if (!b.closed_limit && !b.open_limit && !stuck_latched) status_q = ST_RUNNING;

    // Current sample: sensor flag, held magnitude, stuck detection.
    if (b.sample_valid) begin
      mag = (b.filtered_current_ma < 0) ? -int'(b.filtered_current_ma)
                                        : int'(b.filtered_current_ma);
      error_q[ERR_SENSOR] = b.raw_current_zero;
      current_q = mag[15:0];
      if (mag >= int'(lid_stall_thr)) begin
        drv = 0;  // ramp level is kept
        tgt = 0;
        stuck_latched = 1'b1;
        status_q = ST_STUCK;
      end
    end

    if (tgt == 0) begin
      if (b.lock_switch) begin
        error_q[ERR_LOCK_SW] = 1'b1;
        lock_q = 1'b0;
      end else begin
        error_q[ERR_LOCK_SW] = 1'b0;
      end
    end

    // Switch flags: first match wins, the spare bit never sets.
    if (b.closed_limit) begin
      switch_q[BTN_CLOSED] = 1'b1;
      switch_q[BTN_OPEN]   = 1'b0;
    end else if (b.open_limit) begin
      switch_q[BTN_OPEN]   = 1'b1;
      switch_q[BTN_CLOSED] = 1'b0;
    end else begin
      switch_q[BTN_LOCK] = b.lock_switch;
    end

    lid_target = tgt[8:0];
    drive_ramp = rmp[9:0];
    gate_ms    = gate[5:0];

    r.motor_drive  = drv[8:0];
    r.lid_status   = status_q;
    r.error_flags  = error_q;
    r.lock_enable  = lock_q;
    r.button_flags = switch_q;
    r.current_ma   = current_q;
    return r;
  endfunction

  function automatic in_item_t lid_beat(input bit cmd, input bit dir_open,
                                        input bit closed, input bit opened,
                                        input bit lock_ok, input bit button,
                                        input logic [7:0] ms, input bit smp,
                                        input bit zero, input logic signed [15:0] cur);
    in_item_t b;
    b.cmd                 = cmd;
    b.run_direction       = dir_open;
    b.closed_limit        = closed;
    b.open_limit          = opened;
    b.lock_switch         = lock_ok;
    b.close_button        = button;
    b.elapsed_ms          = ms;
    b.sample_valid        = smp;
    b.raw_current_zero    = zero;
    b.filtered_current_ma = cur;
    return b;
  endfunction

  // Send one beat: optional random gap, then hold until accepted.
  // Called at a rising edge; returns at the edge that took the beat.
  task automatic send_beat(input in_item_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    lid_results_q.push_back(lid_decision(b));
    beats_sent++;
  endtask

  // Stop sending and wait until every expected beat has come back.
  task automatic settle_lid();
    in_valid <= 1'b0;
    while (lid_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);  // covers the input and result registers
  endtask

  // Write all three registers back to back while the block is idle.
  task automatic configure(input logic [7:0] open_spd, input logic [7:0] close_spd,
                           input logic [15:0] thr);
    settle_lid();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_OPEN_SPEED;
    cfg_wdata <= {8'h00, open_spd};
    @(posedge clk);
    cfg_index <= CFG_CLOSE_SPEED;
    cfg_wdata <= {8'h00, close_spd};
    @(posedge clk);
    cfg_index <= CFG_STALL_THR;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    lid_open_spd  = open_spd;
    lid_close_spd = close_spd;
    lid_stall_thr = thr;
  endtask

  // Runs from reset defaults: the reset target opens first, then requests
  // while busy, lock error, close run to the limit, open run to the limit.
  task automatic test_open_close_runs();
    send_beat(lid_beat(0, 0, 0, 0, 1, 0, 8'd10, 0, 0, 16'sd0));
    send_beat(lid_beat(1, 0, 0, 0, 1, 0, 8'd10, 0, 0, 16'sd0));  // busy, ignored
    send_beat(lid_beat(0, 0, 0, 0, 0, 0, 8'd10, 0, 0, 16'sd0));  // lock error
    send_beat(lid_beat(1, 0, 0, 0, 1, 0, 8'd10, 0, 0, 16'sd0));
    send_beat(lid_beat(0, 0, 1, 0, 1, 0, 8'd10, 0, 0, 16'sd0));  // closed limit
    send_beat(lid_beat(1, 1, 0, 0, 1, 0, 8'd10, 0, 0, 16'sd0));
    send_beat(lid_beat(0, 0, 0, 1, 1, 0, 8'd10, 0, 0, 16'sd0));  // open limit
    send_beat(lid_beat(1, 1, 1, 1, 1, 0, 8'd0, 0, 0, 16'sd0));   // both limits
  endtask

  // Close button: gate open, then presses before and at the 50 ms mark.
  task automatic test_button_gate();
    send_beat(lid_beat(0, 0, 0, 0, 1, 1, 8'd0, 0, 0, 16'sd0));
    send_beat(lid_beat(0, 0, 1, 0, 1, 0, 8'd10, 0, 0, 16'sd0));
    send_beat(lid_beat(0, 0, 0, 0, 1, 1, 8'd20, 0, 0, 16'sd0));  // 30 ms
    send_beat(lid_beat(0, 0, 0, 0, 1, 1, 8'd19, 0, 0, 16'sd0));  // 49 ms
    send_beat(lid_beat(0, 0, 0, 0, 1, 1, 8'd1, 0, 0, 16'sd0));   // 50 ms, starts
    send_beat(lid_beat(0, 0, 1, 0, 1, 1, 8'd255, 0, 0, 16'sd0));
  endtask

  // Threshold edge, stuck latch with ramp-down, zero reading, current extremes.
  task automatic test_stall_and_sensor();
    send_beat(lid_beat(1, 1, 0, 0, 1, 0, 8'd5, 1, 0, 16'sd649));
    send_beat(lid_beat(0, 0, 0, 0, 1, 0, 8'd5, 1, 0, 16'sd650));
    send_beat(lid_beat(0, 0, 0, 0, 1, 0, 8'd5, 1, 1, 16'sd0));
    send_beat(lid_beat(0, 0, 0, 0, 0, 0, 8'd5, 1, 0, 16'sh8000));
    send_beat(lid_beat(0, 0, 0, 0, 1, 0, 8'd5, 1, 0, 16'sh7fff));
    send_beat(lid_beat(1, 0, 0, 0, 1, 0, 8'd255, 1, 0, -16'sd1));
  endtask

  // Register extremes: zero speeds with zero threshold, then full scale.
  task automatic test_register_extremes();
    configure(8'd0, 8'd0, 16'd0);
    send_beat(lid_beat(1, 1, 0, 0, 1, 0, 8'd3, 1, 0, 16'sd0));
    send_beat(lid_beat(1, 0, 0, 0, 0, 1, 8'd60, 0, 0, 16'sd0));
    configure(8'd255, 8'd255, 16'hffff);
    send_beat(lid_beat(1, 1, 0, 0, 1, 0, 8'd3, 1, 0, 16'sh8000));
    send_beat(lid_beat(1, 0, 0, 0, 1, 0, 8'd3, 1, 0, 16'sh7fff));
  endtask

  // Mostly whole runs (start, random running beats, end at the limit),
  // with some fully random beats mixed in.
  task automatic test_random_traffic(input int unsigned n_beats);
    int unsigned first;
    int unsigned len;
    int mag;
    bit closing;
    in_item_t b;
    first = beats_sent;
    while (beats_sent - first < n_beats) begin
      if ($urandom_range(5) == 0) begin
        send_beat(in_item_t'($urandom));
      end else begin
        closing = 1'($urandom_range(1));
        b = '0;
        b.lock_switch = 1'b1;
        b.elapsed_ms  = 8'($urandom_range(30));
        if (closing && $urandom_range(1)) begin
          b.close_button = 1'b1;
        end else begin
          b.cmd = 1'b1;
          b.run_direction = !closing;
        end
        send_beat(b);
        // Some runs are long enough for the ramp to reach full speed.
        len = ($urandom_range(4) == 0) ? $urandom_range(130, 60) : $urandom_range(25, 1);
        repeat (len) begin
          b = '0;
          b.lock_switch      = ($urandom_range(24) != 0);
          b.close_button     = ($urandom_range(9) == 0);
          b.cmd              = ($urandom_range(9) == 0);
          b.run_direction    = 1'($urandom_range(1));
          b.elapsed_ms       = ($urandom_range(19) == 0) ? 8'($urandom_range(255))
                                                         : 8'($urandom_range(20));
          b.sample_valid     = ($urandom_range(2) == 0);
          b.raw_current_zero = ($urandom_range(15) == 0);
          // Mostly below the threshold, now and then above it.
          if ($urandom_range(15) == 0)
            mag = $urandom_range(int'(lid_stall_thr) * 2 + 1);
          else
            mag = $urandom_range(int'(lid_stall_thr) * 7 / 8);
          if (mag > 32767) mag = 32767;
          b.filtered_current_ma = $urandom_range(1) ? 16'(-mag) : 16'(mag);
          send_beat(b);
        end
        b = '0;
        b.lock_switch = 1'($urandom_range(1));
        b.elapsed_ms  = 8'($urandom_range(20));
        if (closing) b.closed_limit = 1'b1;
        else         b.open_limit   = 1'b1;
        send_beat(b);
      end
    end
  endtask

  // Random backpressure on the result side.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // Result checker: every taken beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (lid_results_q.size() == 0) begin
        $error("result beat with nothing expected");
        mismatch_count++;
      end else begin
        want = lid_results_q.pop_front();
        if (out_data.motor_drive !== want.motor_drive) begin
          $error("motor_drive exp %0d got %0d", want.motor_drive, out_data.motor_drive);
          mismatch_count++;
        end
        if (out_data.lid_status !== want.lid_status) begin
          $error("lid_status exp %0d got %0d", want.lid_status, out_data.lid_status);
          mismatch_count++;
        end
        if (out_data.error_flags !== want.error_flags) begin
          $error("error_flags exp %b got %b", want.error_flags, out_data.error_flags);
          mismatch_count++;
        end
        if (out_data.lock_enable !== want.lock_enable) begin
          $error("lock_enable exp %b got %b", want.lock_enable, out_data.lock_enable);
          mismatch_count++;
        end
        if (out_data.button_flags !== want.button_flags) begin
          $error("button_flags exp %b got %b", want.button_flags, out_data.button_flags);
          mismatch_count++;
        end
        if (out_data.current_ma !== want.current_ma) begin
          $error("current_ma exp %0d got %0d", want.current_ma, out_data.current_ma);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    // Synchronous reset held first; the predictor starts at reset state.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part runs with no idling; it starts on reset register values.
    test_open_close_runs();
    test_button_gate();
    test_stall_and_sensor();
    test_register_extremes();

    // Random part: one register setting and idling mix per phase.
    configure(OPEN_SPEED_RST, CLOSE_SPEED_RST, STALL_THR_RST);
    test_random_traffic(175);

    send_idle_pct = 61;
    configure(8'd120, 8'd90, 16'd300);
    test_random_traffic(175);

    send_idle_pct = 0;
    rx_stall_pct  = 61;
    configure(8'd255, 8'd1, 16'd2000);
    test_random_traffic(175);

    send_idle_pct = 28;
    rx_stall_pct  = 28;
    configure(8'd81, 8'd255, 16'hffff);
    test_random_traffic(175);

    settle_lid();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: fires far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
